>>> design/dipc_pkg.sv
// ----------------------------------------------------------------------------
// dipc_pkg: shared types and constants for the decimal integer parser
// Item structs for both channels, the status codes, the accumulator snapshot
// handed from the accumulate stage to the check stage, and the range table.
// ----------------------------------------------------------------------------
package dipc_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned TypeW  = 3;
  localparam int unsigned ValueW = 64;
  localparam int unsigned DigitW = 4;

  // Largest magnitude that can still be multiplied by ten and take a digit.
  localparam logic [ValueW-1:0] MagTenLimit = 64'd1844674407370955161;
  localparam logic [DigitW-1:0] MaxLastDigit = 4'd5;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharPlus  = 8'h2b;
  localparam logic [CharW-1:0] CharMinus = 8'h2d;

  typedef enum logic [TypeW-1:0] {
    TYPE_U8  = 3'd0,
    TYPE_U16 = 3'd1,
    TYPE_U32 = 3'd2,
    TYPE_U64 = 3'd3,
    TYPE_I8  = 3'd4,
    TYPE_I16 = 3'd5,
    TYPE_I32 = 3'd6,
    TYPE_I64 = 3'd7
  } num_type_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_CHAR  = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_NO_DIGITS = 2'd3
  } status_e;

  typedef struct packed {
    logic [CharW-1:0] char_in;
    logic [TypeW-1:0] num_type;
    logic             last_char;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [ValueW-1:0] value;
  } out_item_t;

  // Accumulator contents at the end of one string.
  typedef struct packed {
    logic [TypeW-1:0]  num_type;
    logic              negative;
    logic [ValueW-1:0] magnitude;
    logic              overflowed;
    logic              bad_seen;
    logic              digit_seen;
  } snap_t;

  // Largest positive value of each target type.
  function automatic logic [ValueW-1:0] pos_limit(input logic [TypeW-1:0] t);
    logic [ValueW-1:0] lim;
    case (num_type_e'(t))
      TYPE_U8:  lim = 64'd255;
      TYPE_U16: lim = 64'd65535;
      TYPE_U32: lim = 64'd4294967295;
      TYPE_U64: lim = 64'hffff_ffff_ffff_ffff;
      TYPE_I8:  lim = 64'd127;
      TYPE_I16: lim = 64'd32767;
      TYPE_I32: lim = 64'd2147483647;
      TYPE_I64: lim = 64'h7fff_ffff_ffff_ffff;
      default:  lim = 64'h7fff_ffff_ffff_ffff;
    endcase
    return lim;
  endfunction

endpackage

>>> design/dipc_accum.sv
// ----------------------------------------------------------------------------
// dipc_accum: per-character accumulate stage
// Holds the parse state of the current string, folds one character into it
// per transfer, and captures a snapshot of the state on the last character.
// ----------------------------------------------------------------------------
module dipc_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  dipc_pkg::in_item_t item_i,
  output logic               item_ready_o,
  output logic               snap_valid_o,
  output dipc_pkg::snap_t    snap_o,
  input  logic               snap_ready_i
);

  logic                                at_start_q, at_start_d;
  logic [dipc_pkg::TypeW-1:0]          type_q, type_d;
  logic                                neg_q, neg_d;
  logic [dipc_pkg::ValueW-1:0]         mag_q, mag_d;
  logic                                ovf_q, ovf_d;
  logic                                bad_q, bad_d;
  logic                                dig_q, dig_d;
  logic                                snap_vld_q;
  dipc_pkg::snap_t                     snap_q;

  logic                                fire;
  logic                                is_digit;
  logic [dipc_pkg::DigitW-1:0]         digit;
  logic [dipc_pkg::ValueW-1:0]         mag_base;
  logic [dipc_pkg::ValueW-1:0]         mag_next;
  logic                                ovf_base;
  logic                                ovf_hit;
  logic [dipc_pkg::CharW-1:0]          char_sub;

  assign item_ready_o = !snap_vld_q || snap_ready_i;
  assign fire         = item_valid_i && item_ready_o;

  assign is_digit = (item_i.char_in >= dipc_pkg::CharZero) &&
                    (item_i.char_in <= dipc_pkg::CharNine);
  assign char_sub = item_i.char_in - dipc_pkg::CharZero;
  assign digit    = char_sub[dipc_pkg::DigitW-1:0];

  // The first character of a string starts from a cleared state.
  assign mag_base = at_start_q ? '0 : mag_q;
  assign ovf_base = at_start_q ? 1'b0 : ovf_q;
  assign mag_next = (mag_base << 3) + (mag_base << 1) +
                    {{(dipc_pkg::ValueW-dipc_pkg::DigitW){1'b0}}, digit};
  assign ovf_hit  = (mag_base > dipc_pkg::MagTenLimit) ||
                    ((mag_base == dipc_pkg::MagTenLimit) && (digit > dipc_pkg::MaxLastDigit));

  always_comb begin
    type_d = at_start_q ? item_i.num_type : type_q;
    neg_d  = at_start_q ? 1'b0 : neg_q;
    mag_d  = mag_base;
    ovf_d  = ovf_base;
    bad_d  = at_start_q ? 1'b0 : bad_q;
    dig_d  = at_start_q ? 1'b0 : dig_q;
    if (is_digit) begin
      dig_d = 1'b1;
      if (!ovf_base) begin
        if (ovf_hit) begin
          ovf_d = 1'b1;
        end else begin
          mag_d = mag_next;
        end
      end
    end else if (at_start_q && (item_i.char_in == dipc_pkg::CharPlus)) begin
      bad_d = bad_d;
    end else if (at_start_q && (item_i.char_in == dipc_pkg::CharMinus) && type_d[2]) begin
      neg_d = 1'b1;
    end else begin
      bad_d = 1'b1;
    end
    at_start_d = item_i.last_char;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      type_q     <= '0;
      neg_q      <= 1'b0;
      mag_q      <= '0;
      ovf_q      <= 1'b0;
      bad_q      <= 1'b0;
      dig_q      <= 1'b0;
      snap_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        at_start_q <= at_start_d;
        type_q     <= type_d;
        neg_q      <= neg_d;
        mag_q      <= mag_d;
        ovf_q      <= ovf_d;
        bad_q      <= bad_d;
        dig_q      <= dig_d;
      end
      if (item_ready_o) begin
        snap_vld_q <= fire && item_i.last_char;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && item_i.last_char) begin
      snap_q.num_type   <= type_d;
      snap_q.negative   <= neg_d;
      snap_q.magnitude  <= mag_d;
      snap_q.overflowed <= ovf_d;
      snap_q.bad_seen   <= bad_d;
      snap_q.digit_seen <= dig_d;
    end
  end

  assign snap_valid_o = snap_vld_q;
  assign snap_o       = snap_q;

endmodule

>>> design/dipc_check.sv
// ----------------------------------------------------------------------------
// dipc_check: final status and value stage
// Classifies a finished string, applies the range of its target type, forms
// the two's complement value, and holds the result in the output register.
// ----------------------------------------------------------------------------
module dipc_check (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                snap_valid_i,
  input  dipc_pkg::snap_t     snap_i,
  output logic                snap_ready_o,
  output logic                out_valid_o,
  output dipc_pkg::out_item_t out_data_o,
  input  logic                out_stall_i
);

  logic                          out_vld_q;
  dipc_pkg::out_item_t           out_q, out_d;
  logic [dipc_pkg::ValueW-1:0]   lim;
  logic [dipc_pkg::ValueW-1:0]   lim_adj;
  logic                          load;

  assign snap_ready_o = !out_vld_q || !out_stall_i;
  assign load         = snap_valid_i && snap_ready_o;

  // A negative magnitude may reach one past the positive limit.
  assign lim     = dipc_pkg::pos_limit(snap_i.num_type);
  assign lim_adj = snap_i.negative ? lim + 64'd1 : lim;

  always_comb begin
    out_d.value = '0;
    if (snap_i.bad_seen) begin
      out_d.status = dipc_pkg::STAT_BAD_CHAR;
    end else if (!snap_i.digit_seen) begin
      out_d.status = dipc_pkg::STAT_NO_DIGITS;
    end else if (snap_i.overflowed || (snap_i.magnitude > lim_adj)) begin
      out_d.status = dipc_pkg::STAT_RANGE;
    end else begin
      out_d.status = dipc_pkg::STAT_OK;
      out_d.value  = snap_i.negative ? (64'd0 - snap_i.magnitude) : snap_i.magnitude;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (snap_ready_o) begin
      out_vld_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> design/decimal_integer_parse_check.sv
// ----------------------------------------------------------------------------
// decimal_integer_parse_check: ASCII decimal string to integer with range check
// Parses one character per transfer into a 64-bit magnitude and reports a
// status and the signed or unsigned value when the last character arrives.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   -------  ---------  ---------------------  ------------------------------
//   input    in         in_valid_i/in_stall_o  char_in, num_type, last_char
//   output   out        out_valid_o/out_stall_i status, value
//
// One character is taken in every cycle when the output side does not stall.
// A character passes the input register, the accumulate stage (multiply by
// ten as a shift-add) and the check stage; the result of the last character
// is registered as a snapshot and then in the output register, which drives
// out_valid_o. Reset clears all valid flags and arms the block for the first
// character of a string. Output stall backs up stage by stage, so in_stall_o
// rises only when every stage holds an item.
//
// Characters that are not last produce no result. The first character of a
// string latches the target type; a leading plus, or a leading minus for the
// signed types, is accepted, and anything else that is not a digit marks the
// string as bad. Status priority is bad character, then no digits, then out
// of range; the value is zero unless the status is ok.
module decimal_integer_parse_check (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dipc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dipc_pkg::out_item_t out_data_o
);

  logic               in_vld_q;
  dipc_pkg::in_item_t in_q;
  logic               acc_ready;
  logic               in_ready;
  logic               snap_valid;
  logic               snap_ready;
  dipc_pkg::snap_t    snap;

  // The input register can take a new transfer when it is empty or its
  // current character moves on to the accumulate stage in this cycle.
  assign in_ready   = !in_vld_q || acc_ready;
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      in_q <= in_data_i;
    end
  end

  dipc_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_vld_q),
    .item_i       (in_q),
    .item_ready_o (acc_ready),
    .snap_valid_o (snap_valid),
    .snap_o       (snap),
    .snap_ready_i (snap_ready)
  );

  dipc_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .snap_ready_o (snap_ready),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

>>> verif/dipc_parse_checker.sv
// ----------------------------------------------------------------------------
// dipc_parse_checker: predicts and checks the decimal integer parser results
// Watches both channels of the parser, keeps its own copy of the parse state,
// queues the status and value that each final character must produce and
// compares every result transfer against the oldest queued number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dipc_parse_checker
  import dipc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_o
);

  localparam int unsigned PrintCap = 40;

  // Parse state of the string in flight.
  logic              at_start;
  num_type_e         cur_type;
  logic              minus_seen;
  logic [ValueW-1:0] mag;
  logic              mag_overflow;
  logic              bad_char_seen;
  logic              any_digit;

  out_item_t parsed_numbers_q[$];

  // Largest magnitude that fits the type, one more for a negative signed value.
  function automatic logic [ValueW:0] magnitude_bound(input num_type_e t, input logic neg);
    logic [TypeW-1:0] code;
    int unsigned      bits;
    logic [ValueW:0]  bound;
    code = t;
    bits = 8 << code[1:0];
    if (code[2]) begin
      bound = ((65'd1 << (bits - 1)) - 65'd1) + (neg ? 65'd1 : 65'd0);
    end else begin
      bound = (65'd1 << bits) - 65'd1;
    end
    return bound;
  endfunction

  task automatic report_mismatch(input string what, input logic [ValueW-1:0] got,
                                 input logic [ValueW-1:0] want);
    if (fail_count_o < PrintCap) begin
      $display("%0t mismatch: %s got 0x%h expected 0x%h", $realtime, what, got, want);
    end
    fail_count_o++;
  endtask

  task automatic parse_char(input in_item_t item);
    logic [ValueW+3:0] grown;
    logic [DigitW-1:0] digit;
    logic              first;
    out_item_t         res;
    first = at_start;
    if (first) begin
      cur_type      = num_type_e'(item.num_type);
      minus_seen    = 1'b0;
      mag           = '0;
      mag_overflow  = 1'b0;
      bad_char_seen = 1'b0;
      any_digit     = 1'b0;
      at_start      = 1'b0;
    end
    if (item.char_in >= CharZero && item.char_in <= CharNine) begin
      digit     = DigitW'(item.char_in - CharZero);
      any_digit = 1'b1;
      if (!mag_overflow) begin
        // Anything above bit 63 after times ten plus digit means overflow.
        grown = {4'b0, mag} * 68'd10 + 68'(digit);
        if (grown[ValueW+3:ValueW] != '0) begin
          mag_overflow = 1'b1;
        end else begin
          mag = grown[ValueW-1:0];
        end
      end
    end else if (first && item.char_in == CharPlus) begin
      // A leading plus changes nothing.
    end else if (first && item.char_in == CharMinus && cur_type[2]) begin
      minus_seen = 1'b1;
    end else begin
      bad_char_seen = 1'b1;
    end

    if (item.last_char) begin
      at_start  = 1'b1;
      res.value = '0;
      if (bad_char_seen) begin
        res.status = STAT_BAD_CHAR;
      end else if (!any_digit) begin
        res.status = STAT_NO_DIGITS;
      end else if (mag_overflow) begin
        res.status = STAT_RANGE;
      end else if ({1'b0, mag} > magnitude_bound(cur_type, minus_seen)) begin
        res.status = STAT_RANGE;
      end else begin
        res.status = STAT_OK;
        res.value  = minus_seen ? (64'd0 - mag) : mag;
      end
      parsed_numbers_q.push_back(res);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (parsed_numbers_q.size() == 0) begin
      report_mismatch("result with nothing expected, value", got.value, '0);
    end else begin
      want = parsed_numbers_q.pop_front();
      if (got.status != want.status) begin
        report_mismatch("status", 64'(got.status), 64'(want.status));
      end
      if (got.value != want.value) begin
        report_mismatch("value", got.value, want.value);
      end
    end
    results_o++;
  endtask

  // Both channels are sampled at the clock edge, before the block's own
  // updates of that edge take effect.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start      = 1'b1;
      cur_type      = TYPE_U8;
      minus_seen    = 1'b0;
      mag           = '0;
      mag_overflow  = 1'b0;
      bad_char_seen = 1'b0;
      any_digit     = 1'b0;
      parsed_numbers_q.delete();
      fail_count_o  = 0;
      results_o     = 0;
      pending_o     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_result(out_data_i);
      end
      if (in_valid_i && !in_stall_i) begin
        parse_char(in_data_i);
      end
      pending_o = parsed_numbers_q.size();
    end
  end

endmodule

>>> verif/decimal_integer_parse_check_tb.sv
// ----------------------------------------------------------------------------
// decimal_integer_parse_check_tb: stimulus and verdict for the decimal parser
// Sends a short directed set of number strings and then random strings, most
// of them well formed around the range limits of each target type, under four
// mixes of sender gaps and receiver stalls. A checker module beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_integer_parse_check_tb;
  import dipc_pkg::*;

  // Cycles without any transfer on either channel before the run is declared
  // hung.
  localparam int unsigned HangLimit    = 2000;
  localparam int unsigned CharTarget   = 1350;
  localparam int unsigned StringsPerMix = 30;
  // Margin after the last awaited result for a stray result to show up.
  localparam int unsigned DrainCycles  = 20;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;

  // Percent chances of an idle sender cycle and of a receiver stall cycle.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  int unsigned chars_sent   = 0;
  int unsigned strings_sent = 0;
  int unsigned quiet_cycles = 0;

  // Characters of the string being built, first character at index zero.
  logic [CharW-1:0] text_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  decimal_integer_parse_check u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  dipc_parse_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results)
  );

  // The receiver stalls independently of what the block offers.
  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Hang detection: any transfer on either side restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= HangLimit) begin
        $display("No transfer for %0d cycles, %0d results still awaited.", HangLimit, pending);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Mix 0 has no idling at all, mix 1 a mostly idle sender, mix 2 a mostly
  // stalling receiver, and mix 3 light idling on both sides.
  task automatic set_idle_mix(input int unsigned mix);
    case (mix)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 76; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 76; end
      default: begin gap_pct = 22; stall_pct = 22; end
    endcase
  endtask

  // One character transfer. The stall is looked at on the falling edge, where
  // it is settled for the coming rising edge, so no race with the block.
  task automatic send_char(input in_item_t item);
    logic stalled;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    chars_sent++;
  endtask

  // Sends the built string. Only the first character carries the real type;
  // the type field of the others is random since the block ignores it there.
  task automatic send_text(input num_type_e t);
    in_item_t item;
    for (int k = 0; k < text_q.size(); k++) begin
      item.char_in   = text_q[k];
      item.num_type  = (k == 0) ? t : TypeW'($urandom_range(7));
      item.last_char = (k == text_q.size() - 1);
      send_char(item);
    end
    text_q.delete();
    strings_sent++;
  endtask

  task automatic send_literal(input string s, input num_type_e t);
    for (int k = 0; k < s.len(); k++) begin
      text_q.push_back(s[k]);
    end
    send_text(t);
  endtask

  task automatic append_decimal(input logic [ValueW+3:0] v);
    logic [CharW-1:0] digits[$];
    do begin
      digits.push_front(CharZero + CharW'(v % 68'd10));
      v = v / 68'd10;
    end while (v != 0);
    foreach (digits[k]) begin
      text_q.push_back(digits[k]);
    end
  endtask

  // Magnitude at the edge of the type's range, used to aim the stimulus.
  function automatic logic [ValueW+3:0] range_edge(input num_type_e t, input logic neg);
    logic [TypeW-1:0] code;
    int unsigned      bits;
    code = t;
    bits = 8 << code[1:0];
    if (code[2]) begin
      return ((68'd1 << (bits - 1)) - 68'd1) + (neg ? 68'd1 : 68'd0);
    end
    return (68'd1 << bits) - 68'd1;
  endfunction

  // Builds and sends one random string. Most strings are well formed with an
  // optional sign, optional leading zeros and digits aimed at the range edges,
  // at the 64-bit overflow point or random; the rest carry junk characters.
  task automatic send_random_string();
    num_type_e        t;
    logic [TypeW-1:0] code;
    logic             neg;
    logic [ValueW+3:0] v;
    int unsigned      pick;
    int unsigned      len;
    int unsigned      pos;
    t    = num_type_e'($urandom_range(7));
    code = t;
    neg  = 1'b0;
    pick = $urandom_range(99);

    if (pick < 4) begin
      // Pure noise: random bytes of any value.
      len = $urandom_range(1, 6);
      repeat (len) text_q.push_back(CharW'($urandom_range(255)));
    end else begin
      // Sign: minus mostly on signed types, now and then on unsigned ones.
      if ($urandom_range(99) < (code[2] ? 40 : 5)) begin
        text_q.push_back(CharMinus);
        neg = 1'b1;
      end else if ($urandom_range(99) < 20) begin
        text_q.push_back(CharPlus);
      end
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 3)) text_q.push_back(CharZero);
      end

      pick = $urandom_range(99);
      if (pick < 50) begin
        // Just below, at or just above the largest magnitude of the type.
        v = range_edge(t, neg) + 68'($urandom_range(4));
        v = (v >= 2) ? v - 68'd2 : 68'd0;
        append_decimal(v);
      end else if (pick < 62) begin
        // Around 2^64, where the magnitude itself overflows.
        append_decimal((68'd1 << 64) - 68'd3 + 68'($urandom_range(6)));
      end else if (pick < 82) begin
        append_decimal(68'({$urandom, $urandom} >> $urandom_range(63)));
      end else begin
        // Random digit runs; an empty run can leave a lone sign.
        len = $urandom_range(0, 22);
        repeat (len) text_q.push_back(CharZero + CharW'($urandom_range(9)));
      end
      if (text_q.size() == 0) begin
        text_q.push_back($urandom_range(1) ? CharPlus : CharMinus);
      end

      // Broken strings: a sign or any byte dropped into a random position.
      if ($urandom_range(99) < 12) begin
        pos = $urandom_range(text_q.size() - 1);
        case ($urandom_range(2))
          0: text_q[pos] = CharPlus;
          1: text_q[pos] = CharMinus;
          default: text_q[pos] = CharW'($urandom_range(255));
        endcase
      end
    end
    send_text(t);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings: single-character strings, a lone sign, a minus on an
    // unsigned type, the most negative i8, a sign after a digit, the u8 edge
    // on both sides, negative zero, and a NUL and a 0xff character.
    set_idle_mix(0);
    send_literal("7", TYPE_U8);
    send_literal("+", TYPE_I8);
    send_literal("-", TYPE_U8);
    send_literal("-128", TYPE_I8);
    send_literal("1+", TYPE_U16);
    send_literal("255", TYPE_U8);
    send_literal("256", TYPE_U8);
    send_literal("-0", TYPE_I32);
    text_q.push_back(8'h00);
    send_text(TYPE_I64);
    text_q.push_back(8'hff);
    send_text(TYPE_U32);

    // Random strings, switching the idle mix every few dozen strings so each
    // mix lands on every stage of the block's work.
    while (chars_sent < CharTarget) begin
      set_idle_mix((strings_sent / StringsPerMix) % 4);
      send_random_string();
    end
    in_valid_i <= 1'b0;
    set_idle_mix(0);

    // Drain: every final character must have produced its result, then run the
    // clock for DrainCycles more, in which a stray result would show up.
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d characters in %0d strings over four idle mixes.",
             chars_sent, strings_sent);
    $display("Compared %0d results, %0d mismatches.", results, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
